// File: rtl/core/pea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_pkg
// shared types and codes of the page extent allocator
// ----------------------------------------------------------------------------
package pea_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OOM         = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

    // per-cell action chosen by the controller for the update beat
    localparam logic [2:0] ACT_HOLD   = 3'd0;
    localparam logic [2:0] ACT_LOAD   = 3'd1; // write start and length
    localparam logic [2:0] ACT_LEN    = 3'd2; // write length only
    localparam logic [2:0] ACT_SH_UP  = 3'd3; // take the lower neighbor
    localparam logic [2:0] ACT_SH_DN  = 3'd4; // take the upper neighbor

    typedef struct packed {
        logic [2:0]  act;
        logic [40:0] len;
    } t_cell_ctl;

endpackage : pea_pkg
`default_nettype wire

// File: rtl/core/page_extent_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_extent_allocator_top
// first-fit page allocator over a sorted, coalescing table of free runs
// ----------------------------------------------------------------------------
// The free runs sit in a row of MAX_RUNS cells kept sorted by start page.
// A command is scanned one entry a cycle by a single compare unit, then the
// whole row is updated at once (shift up to insert, shift down to drop,
// or a single entry rewritten). The idle state accepts a command, and the
// scan is followed by an update state and an output state that holds the
// result until the consumer takes it; a zero count, or a free past the top
// of the space, skips the scan. One result beat per command beat.
module page_extent_allocator_top #(
    parameter int MAX_RUNS       = 16,
    parameter int PAGE_ADDR_BITS = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,  // page_addr[19:0], page_count[40:20]
    input  wire         s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata   // alloc_addr[19:0], status[22:20]
);
    import pea_pkg::*;

    localparam int AW = PAGE_ADDR_BITS;
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_UPD = 2'd2, S_OUT = 2'd3;

    logic [1:0]    r_state;
    logic          r_cmd;
    logic [AW-1:0] r_addr;
    logic [AW+1:0] r_end;
    logic [20:0]   r_cnt;
    logic [CW-1:0] r_nruns, r_i;
    logic [AW+1:0] r_prv_e;
    logic [AW:0]   r_prv_l;
    logic          r_hasprv;
    logic [19:0]   r_oaddr;
    logic [2:0]    r_ost;

    logic [AW-1:0] w_start [MAX_RUNS];
    logic [AW:0]   w_len   [MAX_RUNS];
    t_cell_ctl     w_ctl   [MAX_RUNS];

    genvar g;
    generate
        for (g = 0; g < MAX_RUNS; g++) begin : g_cell
            pea_cell #(.AW(AW)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl[g]),
                .i_start   (r_addr),
                .i_lo_start(w_start[(g == 0) ? 0 : g-1]),
                .i_lo_len  (w_len[(g == 0) ? 0 : g-1]),
                .i_hi_start(w_start[(g == MAX_RUNS-1) ? g : g+1]),
                .i_hi_len  (w_len[(g == MAX_RUNS-1) ? g : g+1]),
                .o_start   (w_start[g]),
                .o_len     (w_len[g])
            );
        end
    endgenerate

    // current entry under the scan pointer
    logic [AW-1:0] w_cs;
    logic [AW:0]   w_cl;
    logic          w_inb;
    assign w_inb = (r_i < r_nruns);
    assign w_cs  = w_start[r_i[IW-1:0]];
    assign w_cl  = w_len[r_i[IW-1:0]];

    logic [AW+1:0] w_cend;
    assign w_cend = {2'b00, w_cs} + {1'b0, w_cl};

    logic [20:0] w_in_cnt;
    logic [AW-1:0] w_in_addr;
    logic [AW+1:0] w_in_end;
    assign w_in_cnt  = s_axis_tdata[40:20];
    assign w_in_addr = AW'(s_axis_tdata[19:0]);
    assign w_in_end  = (AW+2)'(w_in_addr) + (AW+2)'(w_in_cnt);

    // one decision at scan stop; update action for the row
    logic          r_go;    // update pending
    logic [1:0]    r_kind;  // 0 load-len, 1 insert, 2 drop, 3 merge both
    logic [CW-1:0] r_ti;
    logic [AW:0]   r_tl;
    logic          r_tload;

    localparam logic [1:0] K_LEN = 2'd0, K_INS = 2'd1, K_DROP = 2'd2, K_BOTH = 2'd3;

    always_comb begin
        for (int k = 0; k < MAX_RUNS; k++) begin
            w_ctl[k].act = ACT_HOLD;
            w_ctl[k].len = 41'(r_tl);
            if (r_state == S_UPD && r_go) begin
                unique case (r_kind)
                    K_LEN: if (CW'(k) == r_ti) w_ctl[k].act = r_tload ? ACT_LOAD : ACT_LEN;
                    K_INS: begin
                        if (CW'(k) == r_ti) w_ctl[k].act = ACT_LOAD;
                        else if (CW'(k) > r_ti && CW'(k) <= r_nruns) w_ctl[k].act = ACT_SH_UP;
                    end
                    K_DROP: if (CW'(k) >= r_ti && CW'(k) + 1'b1 < r_nruns) w_ctl[k].act = ACT_SH_DN;
                    K_BOTH: begin
                        if (CW'(k) + 1'b1 == r_ti) w_ctl[k].act = ACT_LEN;
                        else if (CW'(k) >= r_ti && CW'(k) + 1'b1 < r_nruns)
                            w_ctl[k].act = ACT_SH_DN;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_ost, r_oaddr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nruns <= '0;
            r_go    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd    <= s_axis_tuser;
                    r_addr   <= w_in_addr;
                    r_cnt    <= w_in_cnt;
                    r_end    <= w_in_end;
                    r_i      <= '0;
                    r_hasprv <= 1'b0;
                    r_go     <= 1'b0;
                    r_oaddr  <= '0;
                    r_ost    <= ST_OK;
                    if (w_in_cnt == '0 ||
                        (s_axis_tuser == CMD_FREE && w_in_end > ((AW+2)'(1) << AW))) begin
                        r_ost   <= ST_BAD_SIZE;
                        r_state <= S_UPD;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (!w_inb) begin
                            r_ost <= ST_OOM;
                            r_state <= S_UPD;
                        end else if ({20'd0, w_cl} == 41'(r_cnt)) begin
                            r_oaddr <= 20'(w_cs);
                            r_go <= 1'b1; r_kind <= K_DROP; r_ti <= r_i;
                            r_state <= S_UPD;
                        end else if (41'(w_cl) > 41'(r_cnt)) begin
                            r_oaddr <= 20'(w_cs + AW'(w_cl - (AW+1)'(r_cnt)));
                            r_go <= 1'b1; r_kind <= K_LEN; r_ti <= r_i; r_tload <= 1'b0;
                            r_tl <= w_cl - (AW+1)'(r_cnt);
                            r_state <= S_UPD;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else if (w_inb && w_cs < r_addr) begin
                        r_prv_l  <= w_cl;
                        r_prv_e  <= w_cend;
                        r_hasprv <= 1'b1;
                        r_i      <= r_i + 1'b1;
                    end else begin
                        r_state <= S_UPD;
                        if ((r_hasprv && r_prv_e > (AW+2)'(r_addr)) ||
                            (w_inb && (AW+2)'(w_cs) < r_end)) begin
                            r_ost <= ST_DOUBLE_FREE;
                        end else if (r_hasprv && r_prv_e == (AW+2)'(r_addr) &&
                                     w_inb && (AW+2)'(w_cs) == r_end) begin
                            r_go <= 1'b1; r_kind <= K_BOTH; r_ti <= r_i;
                            r_tl <= r_prv_l + (AW+1)'(r_cnt) + w_cl;
                        end else if (r_hasprv && r_prv_e == (AW+2)'(r_addr)) begin
                            r_go <= 1'b1; r_kind <= K_LEN; r_ti <= r_i - 1'b1;
                            r_tload <= 1'b0; r_tl <= r_prv_l + (AW+1)'(r_cnt);
                        end else if (w_inb && (AW+2)'(w_cs) == r_end) begin
                            r_go <= 1'b1; r_kind <= K_LEN; r_ti <= r_i; r_tload <= 1'b1;
                            r_tl <= w_cl + (AW+1)'(r_cnt);
                        end else if (r_nruns >= CW'(MAX_RUNS)) begin
                            r_ost <= ST_TABLE_FULL;
                        end else begin
                            r_go <= 1'b1; r_kind <= K_INS; r_ti <= r_i;
                            r_tl <= (AW+1)'(r_cnt);
                        end
                    end
                end
                S_UPD: begin
                    if (r_go) begin
                        if (r_kind == K_INS) r_nruns <= r_nruns + 1'b1;
                        else if (r_kind == K_DROP || r_kind == K_BOTH)
                            r_nruns <= r_nruns - 1'b1;
                    end
                    r_go    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^s_axis_tdata[47:41];
endmodule
`default_nettype wire

// File: rtl/core/pea_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_cell
// one free-run table entry; shifts to a neighbor or loads on command
// ----------------------------------------------------------------------------
module pea_cell #(
    parameter int AW = 20
) (
    input  wire                   i_clk,
    input  wire pea_pkg::t_cell_ctl i_ctl,
    input  wire [AW-1:0]          i_start,
    input  wire [AW-1:0]          i_lo_start,
    input  wire [AW:0]            i_lo_len,
    input  wire [AW-1:0]          i_hi_start,
    input  wire [AW:0]            i_hi_len,
    output logic [AW-1:0]         o_start,
    output logic [AW:0]           o_len
);
    import pea_pkg::*;

    logic [AW-1:0] r_start;
    logic [AW:0]   r_len;

    always_ff @(posedge i_clk) begin
        case (i_ctl.act)
            ACT_LOAD: begin
                r_start <= i_start;
                r_len   <= i_ctl.len[AW:0];
            end
            ACT_LEN:   r_len <= i_ctl.len[AW:0];
            ACT_SH_UP: begin
                r_start <= i_lo_start;
                r_len   <= i_lo_len;
            end
            ACT_SH_DN: begin
                r_start <= i_hi_start;
                r_len   <= i_hi_len;
            end
            default: ;
        endcase
    end

    assign o_start = r_start;
    assign o_len   = r_len;
endmodule
`default_nettype wire

// File: dv/page_extent_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_extent_allocator_top_tb
// self-checking bench for the first-fit page allocator with coalescing
// ----------------------------------------------------------------------------
// A directed table covers zero sizes, frees past the top of the space,
// overlaps of several kinds, merges on each side, a full table and no-fit
// allocations. A random part follows with frees and allocations of mostly
// small sizes in a narrow address window, so the table fills, merges and
// drains. Every result is compared against a local model of the run table.
module page_extent_allocator_top_tb;
    import pea_pkg::*;

    localparam int NRUNS = 16;
    localparam int ABITS = 20;
    localparam logic [20:0] SPACE = 21'd1 << ABITS;

    typedef struct {
        logic        cmd;
        logic [19:0] addr;
        logic [20:0] count;
        logic        has_exp;
        logic [19:0] exp_addr;
        logic [2:0]  exp_st;
    } t_cmd_row;

    typedef struct {
        logic [19:0] addr;
        logic [2:0]  st;
    } t_alloc_res;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [47:0] s_data;
    logic        s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;

    logic [19:0] free_start [NRUNS];
    logic [20:0] free_len [NRUNS];
    int          free_cnt;
    t_alloc_res  pending_q [$];
    t_cmd_row    dir_rows [$];
    int          errors;

    page_extent_allocator_top #(
        .MAX_RUNS      (NRUNS),
        .PAGE_ADDR_BITS(ABITS)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),  // page_addr[19:0], page_count[40:20]
        .s_axis_tuser (s_user),  // cmd
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data)   // alloc_addr[19:0], status[22:20]
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void drop_run(int idx);
        for (int k = idx; k + 1 < free_cnt; k++) begin
            free_start[k] = free_start[k + 1];
            free_len[k]   = free_len[k + 1];
        end
        free_cnt--;
    endfunction

    function automatic t_alloc_res predict_alloc(logic cmd, logic [19:0] addr,
                                                 logic [20:0] n);
        t_alloc_res r;
        logic [21:0] last;
        int i;
        bit lo, hi;
        r.addr = '0;
        r.st   = ST_OK;
        i      = 0;
        if (n == 0) begin
            r.st = ST_BAD_SIZE;
            return r;
        end
        if (cmd == CMD_ALLOC) begin
            for (i = 0; i < free_cnt; i++) begin
                if (free_len[i] == n) begin
                    r.addr = free_start[i];
                    drop_run(i);
                    return r;
                end
                if (free_len[i] > n) begin
                    free_len[i] = free_len[i] - n;
                    r.addr = 20'(free_start[i] + free_len[i]);
                    return r;
                end
            end
            r.st = ST_OOM;
            return r;
        end
        last = 22'(addr) + 22'(n);
        if (last > 22'(SPACE)) begin
            r.st = ST_BAD_SIZE;
            return r;
        end
        while (i < free_cnt && free_start[i] < addr) i++;
        if ((i > 0 && 22'(free_start[i-1]) + 22'(free_len[i-1]) > 22'(addr)) ||
            (i < free_cnt && 22'(free_start[i]) < last)) begin
            r.st = ST_DOUBLE_FREE;
            return r;
        end
        lo = (i > 0) && (22'(free_start[i-1]) + 22'(free_len[i-1]) == 22'(addr));
        hi = (i < free_cnt) && (22'(free_start[i]) == last);
        if (lo && hi) begin
            free_len[i-1] = free_len[i-1] + n + free_len[i];
            drop_run(i);
        end else if (lo) begin
            free_len[i-1] = free_len[i-1] + n;
        end else if (hi) begin
            free_start[i] = addr;
            free_len[i]   = free_len[i] + n;
        end else begin
            if (free_cnt >= NRUNS) begin
                r.st = ST_TABLE_FULL;
                return r;
            end
            for (int k = free_cnt; k > i; k--) begin
                free_start[k] = free_start[k-1];
                free_len[k]   = free_len[k-1];
            end
            free_start[i] = addr;
            free_len[i]   = n;
            free_cnt++;
        end
        return r;
    endfunction

    function automatic void add_row(logic cmd, logic [19:0] addr, logic [20:0] n,
                                    logic has, logic [19:0] ea, logic [2:0] es);
        t_cmd_row r;
        r.cmd = cmd; r.addr = addr; r.count = n;
        r.has_exp = has; r.exp_addr = ea; r.exp_st = es;
        dir_rows.push_back(r);
    endfunction

    task automatic send_cmd(logic cmd, logic [19:0] addr, logic [20:0] n,
                            logic has, logic [19:0] ea, logic [2:0] es);
        t_alloc_res r;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {7'd0, n, addr};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        r = predict_alloc(cmd, addr, n);
        if (has && (r.addr !== ea || r.st !== es)) begin
            $display("%0t directed row mismatch: expected addr %h st %0d, model %h %0d",
                     $time, ea, es, r.addr, r.st);
            errors++;
        end
        pending_q.push_back(r);
    endtask

    // result side: random stall per beat
    initial begin
        int stall;
        t_alloc_res e;
        m_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_data[19:0] !== e.addr) begin
                    $display("%0t alloc_addr mismatch: expected %h actual %h",
                             $time, e.addr, m_data[19:0]);
                    errors++;
                end
                if (m_data[22:20] !== e.st) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, e.st, m_data[22:20]);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic        c;
        logic [19:0] a;
        logic [20:0] n;
        int          pick;
        errors    = 0;
        free_cnt  = 0;
        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_user    = CMD_ALLOC;
        s_data    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        add_row(CMD_ALLOC, 20'd0, 21'd1, 1, 20'd0, ST_OOM);
        add_row(CMD_ALLOC, 20'hFFFFF, 21'd0, 1, 20'd0, ST_BAD_SIZE);
        add_row(CMD_FREE, 20'd5, 21'd0, 1, 20'd0, ST_BAD_SIZE);
        add_row(CMD_FREE, 20'hFFFFF, 21'd2, 1, 20'd0, ST_BAD_SIZE);
        add_row(CMD_FREE, 20'd1, 21'h100000, 1, 20'd0, ST_BAD_SIZE);
        add_row(CMD_FREE, 20'd0, 21'h100000, 1, 20'd0, ST_OK);
        add_row(CMD_ALLOC, 20'd0, 21'h1FFFFF, 1, 20'd0, ST_OOM);
        add_row(CMD_FREE, 20'd100, 21'd1, 1, 20'd0, ST_DOUBLE_FREE);
        add_row(CMD_ALLOC, 20'd0, 21'h100000, 1, 20'd0, ST_OK);
        add_row(CMD_FREE, 20'hFFFFF, 21'd1, 1, 20'd0, ST_OK);
        add_row(CMD_ALLOC, 20'd0, 21'd1, 1, 20'hFFFFF, ST_OK);
        add_row(CMD_FREE, 20'd100, 21'd10, 0, 0, 0);
        add_row(CMD_FREE, 20'd105, 21'd2, 0, 0, 0);   // inside a run
        add_row(CMD_FREE, 20'd95, 21'd10, 0, 0, 0);   // tail overlaps
        add_row(CMD_FREE, 20'd90, 21'd10, 0, 0, 0);   // merge below it
        add_row(CMD_FREE, 20'd120, 21'd5, 0, 0, 0);
        add_row(CMD_FREE, 20'd110, 21'd10, 0, 0, 0);  // merge both sides
        add_row(CMD_FREE, 20'd125, 21'd3, 0, 0, 0);   // merge above
        add_row(CMD_ALLOC, 20'd0, 21'd38, 0, 0, 0);   // exact fit
        for (int k = 0; k < 16; k++)
            add_row(CMD_FREE, 20'(k * 4), 21'd1, 0, 0, 0);
        add_row(CMD_FREE, 20'd200, 21'd1, 1, 20'd0, ST_TABLE_FULL);
        add_row(CMD_FREE, 20'd1, 21'd1, 0, 0, 0);     // merge when full
        add_row(CMD_ALLOC, 20'd0, 21'd5, 1, 20'd0, ST_OOM);
        add_row(CMD_ALLOC, 20'd0, 21'd2, 0, 0, 0);
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].count,
                     dir_rows[i].has_exp, dir_rows[i].exp_addr, dir_rows[i].exp_st);

        for (int it = 0; it < 800; it++) begin
            pick = $urandom_range(0, 99);
            c = (pick < 55) ? CMD_FREE : CMD_ALLOC;
            a = 20'($urandom_range(0, 255));
            n = 21'($urandom_range(1, 12));
            if (pick >= 95) begin
                // full-width noise to toggle every bit
                a = 20'($urandom);
                n = 21'($urandom);
            end else if (pick >= 92) begin
                n = 21'd0;
            end else if (pick < 8) begin
                a = 20'hFFFFF - 20'($urandom_range(0, 15));
            end
            send_cmd(c, a, n, 0, 0, 0);
        end
        @(negedge clk);
        s_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
